// File: rtl/stc_pkg.sv
// Package for the stick-to-octant coil drive unit.
// Holds shared constants and the stage control type; depends on nothing.
`default_nettype none

package stc_pkg;

  localparam int STICK_BITS_DEF = 12;
  localparam int COIL_COUNT_DEF = 8;

  localparam int INDEX_W  = 3;
  localparam int POWER_W  = 13;
  localparam int LEVEL_W  = 8;
  localparam int SECTOR_W = 3;

  localparam int unsigned TAN_Q16   = 27146;
  localparam int          Q16_SHIFT = 16;
  localparam int unsigned POWER_MAX = 4095;

  localparam logic [LEVEL_W-1:0] REVERSE_RESET = 8'd8;

  typedef struct packed {
    logic                valid;
    logic [SECTOR_W-1:0] sector;
  } stage_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/stc_prep.sv
// Front stage: squares the stick sample and picks its 45-degree sector.
// Depends on stc_pkg.
`default_nettype none

module stc_prep #(
  parameter int STICK_BITS = stc_pkg::STICK_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire logic                    in_valid,
  input  wire logic [STICK_BITS-1:0]   stick_x,
  input  wire logic [STICK_BITS-1:0]   stick_y,
  output stc_pkg::stage_ctrl_t         ctrl,
  output logic [2*STICK_BITS-1:0]      radicand
);
  import stc_pkg::*;

  localparam int RW = 2 * STICK_BITS;
  localparam int PW = STICK_BITS + Q16_SHIFT + 1;

  logic signed [STICK_BITS-1:0] sx;
  logic signed [STICK_BITS-1:0] sy;
  logic signed [RW-1:0]         px;
  logic signed [RW-1:0]         py;
  logic signed [STICK_BITS:0]   ex;
  logic signed [STICK_BITS:0]   ey;
  logic signed [STICK_BITS:0]   nx;
  logic signed [STICK_BITS:0]   ny;
  logic [STICK_BITS-1:0]        uu;
  logic [STICK_BITS-1:0]        vv;
  logic [1:0]                   quad;
  logic [1:0]                   sub;
  logic [SECTOR_W-1:0]          sector_next;
  logic [RW-1:0]                xx;
  logic [RW-1:0]                yy;

  always_comb begin
    sx = $signed(stick_x);
    sy = $signed(stick_y);
    px = RW'(sx) * RW'(sx);
    py = RW'(sy) * RW'(sy);
    ex = (STICK_BITS + 1)'(sx);
    ey = (STICK_BITS + 1)'(sy);
    nx = -ex;
    ny = -ey;
    if (ex > 0 && ey >= 0) begin
      quad = 2'd0;
      uu = STICK_BITS'(ex);
      vv = STICK_BITS'(ey);
    end else if (ex <= 0 && ey > 0) begin
      quad = 2'd1;
      uu = STICK_BITS'(ey);
      vv = STICK_BITS'(nx);
    end else if (ex < 0 && ey <= 0) begin
      quad = 2'd2;
      uu = STICK_BITS'(nx);
      vv = STICK_BITS'(ny);
    end else begin
      quad = 2'd3;
      uu = STICK_BITS'(ny);
      vv = STICK_BITS'(ex);
    end
    if ((PW'(vv) << Q16_SHIFT) < PW'(uu) * PW'(TAN_Q16)) begin
      sub = 2'd0;
    end else if ((PW'(uu) << Q16_SHIFT) <= PW'(vv) * PW'(TAN_Q16)) begin
      sub = 2'd2;
    end else begin
      sub = 2'd1;
    end
    if (ex == 0 && ey == 0) begin
      sector_next = '0;
    end else begin
      sector_next = SECTOR_W'({quad, 1'b0}) + SECTOR_W'(sub);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (advance) begin
      ctrl.valid <= in_valid;
    end
    if (advance) begin
      ctrl.sector <= sector_next;
      xx <= RW'($unsigned(px));
      yy <= RW'($unsigned(py));
    end
  end

  assign radicand = xx + yy;

endmodule

`default_nettype wire

// File: rtl/stc_cell.sv
// One cell of the square root chain: settles one result bit per cycle while advance is high.
// Depends on stc_pkg.
`default_nettype none

module stc_cell #(
  parameter int RW   = 2 * stc_pkg::STICK_BITS_DEF,
  parameter int STEP = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire stc_pkg::stage_ctrl_t ctrl_in,
  input  wire logic [RW-1:0]        rem_in,
  input  wire logic [RW-1:0]        root_in,
  output stc_pkg::stage_ctrl_t      ctrl_out,
  output logic [RW-1:0]             rem_out,
  output logic [RW-1:0]             root_out
);
  import stc_pkg::*;

  localparam logic [RW-1:0] STEP_BIT = RW'(1) << (2 * STEP);

  logic [RW-1:0] trial;
  logic          fits;
  logic [RW-1:0] rem_next;
  logic [RW-1:0] root_next;

  always_comb begin
    trial = root_in + STEP_BIT;
    fits  = rem_in >= trial;
    if (fits) begin
      rem_next  = rem_in - trial;
      root_next = (root_in >> 1) + STEP_BIT;
    end else begin
      rem_next  = rem_in;
      root_next = root_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (advance) begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    if (advance) begin
      ctrl_out.sector <= ctrl_in.sector;
      rem_out  <= rem_next;
      root_out <= root_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stc_serial.sv
// Output stage: holds one finished sample and sends its coil results in order.
// Depends on stc_pkg.
`default_nettype none

module stc_serial #(
  parameter int RW         = 2 * stc_pkg::STICK_BITS_DEF,
  parameter int COIL_COUNT = stc_pkg::COIL_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire stc_pkg::stage_ctrl_t        ctrl_in,
  input  wire logic [RW-1:0]               root_in,
  input  wire logic [stc_pkg::LEVEL_W-1:0] reverse_level,
  output logic                             ready,
  output logic                             valid,
  input  wire logic                        take,
  output logic [stc_pkg::INDEX_W-1:0]      coil_index,
  output logic                             coil_forward,
  output logic [stc_pkg::POWER_W-1:0]      coil_power,
  output logic                             last_coil
);
  import stc_pkg::*;

  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(COIL_COUNT - 1);

  logic [INDEX_W-1:0]  count;
  logic [SECTOR_W-1:0] sector;
  logic [POWER_W-1:0]  magnitude;
  logic [POWER_W-1:0]  mag_next;
  logic                load;

  always_comb begin
    if (32'(root_in) > POWER_MAX) begin
      mag_next = POWER_W'(POWER_MAX);
    end else begin
      mag_next = POWER_W'(root_in);
    end
    last_coil    = count == LAST_INDEX;
    ready        = !valid || (take && last_coil);
    load         = ctrl_in.valid && ready;
    coil_index   = count;
    coil_forward = count == sector;
    if (coil_forward) begin
      coil_power = magnitude;
    end else begin
      coil_power = POWER_W'(0) - POWER_W'(reverse_level);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= '0;
    end else if (load) begin
      valid <= 1'b1;
      count <= '0;
    end else if (valid && take) begin
      if (last_coil) begin
        valid <= 1'b0;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sector    <= ctrl_in.sector;
      magnitude <= mag_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stick_to_octant_coil_drive_unit.sv
// Top level of the stick-to-octant coil drive unit.
// Depends on stc_pkg, stc_prep, stc_cell and stc_serial.
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_tvalid / s_tready        s_tdata: stick sample
//   m_axis    out        m_tvalid / m_tready        m_tdata, m_tlast: coil result
//   cfg       in         cfg_valid / cfg_ready      cfg_data: reverse level
//
// A sample passes one front stage and STICK_BITS square root cells, and is then
// loaded into the serializer, which registers it before its first coil result.
// Each sample then gives eight results, one per cycle while the output does not
// stall; the serializer sets the sample rate, taking a new one as the last result goes.
// Reset clears the valid flags and sets the reverse level to 8; there is no fill.
// A sample waiting in the last cell behind a busy serializer freezes the whole
// chain and holds s_tready low.
`default_nettype none

module stick_to_octant_coil_drive_unit #(
  parameter int STICK_BITS = stc_pkg::STICK_BITS_DEF,
  parameter int COIL_COUNT = stc_pkg::COIL_COUNT_DEF,
  parameter int IN_BYTES   = (2 * STICK_BITS + 7) / 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // s_tdata fields from bit 0: stick_x, stick_y, zero fill
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [8*IN_BYTES-1:0]       s_tdata,
  // m_tdata fields from bit 0: coil_index, coil_forward, coil_power, zero fill
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [23:0]                      m_tdata,
  output logic                             m_tlast,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [stc_pkg::LEVEL_W-1:0] cfg_data
);
  import stc_pkg::*;

  localparam int RW = 2 * STICK_BITS;

  logic [LEVEL_W-1:0]  reverse_level;
  logic                advance;
  logic                ser_ready;
  stage_ctrl_t         ctrl  [STICK_BITS+1];
  logic [RW-1:0]       rem   [STICK_BITS+1];
  logic [RW-1:0]       root  [STICK_BITS+1];
  logic [INDEX_W-1:0]  coil_index;
  logic                coil_forward;
  logic [POWER_W-1:0]  coil_power;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_level <= REVERSE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      reverse_level <= cfg_data;
    end
  end

  assign advance  = !ctrl[STICK_BITS].valid || ser_ready;
  assign s_tready = advance;
  assign root[0]  = '0;

  stc_prep #(
    .STICK_BITS(STICK_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (s_tvalid),
    .stick_x  (s_tdata[STICK_BITS-1:0]),
    .stick_y  (s_tdata[2*STICK_BITS-1:STICK_BITS]),
    .ctrl     (ctrl[0]),
    .radicand (rem[0])
  );

  for (genvar i = 0; i < STICK_BITS; i++) begin : g_cell
    stc_cell #(
      .RW   (RW),
      .STEP (STICK_BITS - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .ctrl_in  (ctrl[i]),
      .rem_in   (rem[i]),
      .root_in  (root[i]),
      .ctrl_out (ctrl[i+1]),
      .rem_out  (rem[i+1]),
      .root_out (root[i+1])
    );
  end

  stc_serial #(
    .RW         (RW),
    .COIL_COUNT (COIL_COUNT)
  ) u_serial (
    .clk           (clk),
    .rst           (rst),
    .ctrl_in       (ctrl[STICK_BITS]),
    .root_in       (root[STICK_BITS]),
    .reverse_level (reverse_level),
    .ready         (ser_ready),
    .valid         (m_tvalid),
    .take          (m_tready),
    .coil_index    (coil_index),
    .coil_forward  (coil_forward),
    .coil_power    (coil_power),
    .last_coil     (m_tlast)
  );

  assign m_tdata = {7'b0, coil_power, coil_forward, coil_index};

  assert property (@(posedge clk) disable iff (rst)
    ctrl[STICK_BITS].valid && !ser_ready |=>
      ctrl[STICK_BITS].valid && $stable(ctrl[STICK_BITS].sector))
    else $error("Last cell lost its sample while the output was stalled.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && m_tdata[2:0] == 3'($past(m_tdata[2:0]) + 3'd1))
    else $error("Coil index did not step within a sample.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast && !ctrl[STICK_BITS].valid |=> !m_tvalid)
    else $error("Output stayed valid with no sample left to send.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> !m_tdata[16])
    else $error("Forward coil power is negative.");

endmodule

`default_nettype wire
